[design/pges_pkg.sv]
package pges_pkg;

    // Field and datapath widths.
    localparam int unsigned FIX_W     = 32;
    localparam int unsigned STR_W     = 24;
    localparam int unsigned MAG_W     = 32;
    localparam int unsigned PROD_W    = STR_W + MAG_W;
    localparam int unsigned SQ_W      = 64;
    localparam int unsigned ROOT_W    = 32;
    localparam int unsigned REM_W     = 36;
    localparam int unsigned DEN_W     = 96;
    localparam int unsigned QUO_W     = 32;
    localparam int unsigned SQ_STEPS  = 32;
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned IN_W      = 6 * FIX_W + STR_W;
    localparam int unsigned OUT_W     = 4 * FIX_W;

    typedef logic signed [FIX_W-1:0] t_fix;

    // Fields that ride along the whole pipeline.
    typedef struct packed {
        t_fix              px;
        t_fix              py;
        t_fix              vx;
        t_fix              vy;
        logic [PROD_W-1:0] prx;
        logic [PROD_W-1:0] pry;
        logic              negx;
        logic              negy;
        logic              zero;
        logic              sat;
    } t_pay;

    // A clamped value and the flag that says the clamp was applied.
    typedef struct packed {
        t_fix val;
        logic ovf;
    } t_clamp;

    localparam logic signed [FIX_W+1:0] FIX_MAX = 34'sh0_7FFF_FFFF;
    localparam logic signed [FIX_W+1:0] FIX_MIN = 34'sh3_8000_0000;

    // Clamp a widened sum to the signed 32-bit range.
    function automatic t_clamp clamp_fix(input logic signed [FIX_W+1:0] v);
        t_clamp c;
        c.ovf = 1'b1;
        if (v > FIX_MAX) begin
            c.val = FIX_MAX[FIX_W-1:0];
        end else if (v < FIX_MIN) begin
            c.val = FIX_MIN[FIX_W-1:0];
        end else begin
            c.val = v[FIX_W-1:0];
            c.ovf = 1'b0;
        end
        return c;
    endfunction

    // Turn an unsigned quotient into a signed, clamped acceleration component (zero when the points coincide).
    function automatic t_clamp accel_of(input logic [QUO_W-1:0] q, input logic ov,
                                        input logic neg, input logic zero);
        t_clamp          c;
        logic [QUO_W:0]  lim;
        logic [QUO_W:0]  m;
        logic signed [QUO_W+1:0] a;
        lim = neg ? {2'b01, {(QUO_W-1){1'b0}}} : {2'b00, {(QUO_W-1){1'b1}}};
        c.ovf = 1'b0;
        m = {1'b0, q};
        if (ov || ({1'b0, q} > lim)) begin
            m = lim;
            c.ovf = 1'b1;
        end
        a = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
        c.val = a[FIX_W-1:0];
        if (zero) begin
            c.val = '0;
            c.ovf = 1'b0;
        end
        return c;
    endfunction

endpackage

[design/point_gravity_euler_step_core.sv]
// Fully pipelined point-gravity Euler step: 72 register stages.
// Throughput: one transaction per cycle; a full output stage that is not taken stalls the whole pipe.
// Depth is set by the 32-stage square root and the 32-stage divider (both axes in parallel).
// Reset (synchronous, active low) clears the valid bits only.
module point_gravity_euler_step_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // body_pos_x, body_pos_y, body_vel_x, body_vel_y, src_pos_x, src_pos_y,
    // source_strength (lowest bit up)
    input  logic [pges_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y (lowest bit up)
    output logic [pges_pkg::OUT_W-1:0]    m_axis_tdata,
    // zero_distance, saturated (lowest bit up)
    output logic [1:0]                    m_axis_tuser
);

    localparam int NW     = pges_pkg::PROD_W + 2 * FRAC_BITS;
    localparam int CW     = (NW > pges_pkg::DEN_W) ? NW : pges_pkg::DEN_W;
    localparam int ST_SQ0 = 2;
    localparam int ST_MP  = ST_SQ0 + pges_pkg::SQ_STEPS + 1;
    localparam int ST_DN  = ST_MP + 1;
    localparam int ST_DV0 = ST_DN + 1;
    localparam int ST_FA  = ST_DV0 + pges_pkg::DIV_STEPS + 1;
    localparam int ST_OUT = ST_FA + 1;
    localparam int NST    = ST_OUT + 1;
    localparam int SQN    = pges_pkg::SQ_STEPS;
    localparam int DVN    = pges_pkg::DIV_STEPS;

    logic en;

    logic [NST-1:0]      r_vld, n_vld;
    pges_pkg::t_pay      r_pay [NST];
    pges_pkg::t_pay      n_pay [NST];

    pges_pkg::t_fix                 r_dx, n_dx, r_dy, n_dy;
    logic [pges_pkg::STR_W-1:0]     r_str, n_str;
    logic [pges_pkg::SQ_W-1:0]      r_sqx, n_sqx, r_sqy, n_sqy;

    logic [pges_pkg::SQ_W-1:0]      r_sq_q    [SQN+1];
    logic [pges_pkg::SQ_W-1:0]      n_sq_q    [SQN+1];
    logic [pges_pkg::REM_W-1:0]     r_sq_rem  [SQN+1];
    logic [pges_pkg::REM_W-1:0]     n_sq_rem  [SQN+1];
    logic [pges_pkg::ROOT_W-1:0]    r_sq_root [SQN+1];
    logic [pges_pkg::ROOT_W-1:0]    n_sq_root [SQN+1];

    logic [pges_pkg::SQ_W-1:0]      r_pp_lo, n_pp_lo, r_pp_hi, n_pp_hi;
    logic [pges_pkg::DEN_W-1:0]     r_den, n_den;

    logic [pges_pkg::DEN_W-1:0]     r_dv_den [DVN+1];
    logic [pges_pkg::DEN_W-1:0]     n_dv_den [DVN+1];
    logic [NW-1:0]                  r_dv_px  [DVN+1];
    logic [NW-1:0]                  n_dv_px  [DVN+1];
    logic [NW-1:0]                  r_dv_py  [DVN+1];
    logic [NW-1:0]                  n_dv_py  [DVN+1];
    logic [pges_pkg::QUO_W-1:0]     r_dv_qx  [DVN+1];
    logic [pges_pkg::QUO_W-1:0]     n_dv_qx  [DVN+1];
    logic [pges_pkg::QUO_W-1:0]     r_dv_qy  [DVN+1];
    logic [pges_pkg::QUO_W-1:0]     n_dv_qy  [DVN+1];
    logic                           r_dv_ovx [DVN+1];
    logic                           n_dv_ovx [DVN+1];
    logic                           r_dv_ovy [DVN+1];
    logic                           n_dv_ovy [DVN+1];

    // The whole pipe advances when the output stage is empty or being taken.
    assign en            = !r_vld[ST_OUT] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[ST_OUT];
    assign m_axis_tdata  = {r_pay[ST_OUT].vy, r_pay[ST_OUT].vx,
                            r_pay[ST_OUT].py, r_pay[ST_OUT].px};
    assign m_axis_tuser  = {r_pay[ST_OUT].sat, r_pay[ST_OUT].zero};

    // Next-state logic for every stage.
    always_comb begin
        pges_pkg::t_fix           in_px, in_py, in_vx, in_vy, in_sx, in_sy;
        pges_pkg::t_clamp         cx, cy, ax, ay, nvx, nvy, npx, npy;
        logic [pges_pkg::MAG_W-1:0] magx, magy;
        logic [pges_pkg::REM_W-1:0] rem_sh, trial;
        logic [NW-1:0]            numx, numy;
        logic [CW-1:0]            den_w, sub, topx, topy;
        logic                     gex, gey;
        int                       b;
        int                       k;

        for (int i = 1; i < NST; i++) begin
            n_pay[i] = r_pay[i-1];
            n_vld[i] = r_vld[i-1];
        end
        n_vld[0] = s_axis_tvalid;

        // Stage 0: unpack, offset from body to source, clamp.
        in_px = s_axis_tdata[0*pges_pkg::FIX_W +: pges_pkg::FIX_W];
        in_py = s_axis_tdata[1*pges_pkg::FIX_W +: pges_pkg::FIX_W];
        in_vx = s_axis_tdata[2*pges_pkg::FIX_W +: pges_pkg::FIX_W];
        in_vy = s_axis_tdata[3*pges_pkg::FIX_W +: pges_pkg::FIX_W];
        in_sx = s_axis_tdata[4*pges_pkg::FIX_W +: pges_pkg::FIX_W];
        in_sy = s_axis_tdata[5*pges_pkg::FIX_W +: pges_pkg::FIX_W];
        n_str = s_axis_tdata[6*pges_pkg::FIX_W +: pges_pkg::STR_W];
        cx = pges_pkg::clamp_fix(34'(in_sx) - 34'(in_px));
        cy = pges_pkg::clamp_fix(34'(in_sy) - 34'(in_py));
        n_dx = cx.val;
        n_dy = cy.val;
        n_pay[0].px   = in_px;
        n_pay[0].py   = in_py;
        n_pay[0].vx   = in_vx;
        n_pay[0].vy   = in_vy;
        n_pay[0].prx  = '0;
        n_pay[0].pry  = '0;
        n_pay[0].negx = cx.val[pges_pkg::FIX_W-1];
        n_pay[0].negy = cy.val[pges_pkg::FIX_W-1];
        n_pay[0].zero = (cx.val == '0) && (cy.val == '0);
        n_pay[0].sat  = cx.ovf | cy.ovf;

        // Stage 1: squares and strength times magnitude.
        magx = r_pay[0].negx ? pges_pkg::MAG_W'(-r_dx) : pges_pkg::MAG_W'(r_dx);
        magy = r_pay[0].negy ? pges_pkg::MAG_W'(-r_dy) : pges_pkg::MAG_W'(r_dy);
        n_pay[1].prx = pges_pkg::PROD_W'(r_str) * pges_pkg::PROD_W'(magx);
        n_pay[1].pry = pges_pkg::PROD_W'(r_str) * pges_pkg::PROD_W'(magy);
        n_sqx = $unsigned(64'(r_dx) * 64'(r_dx));
        n_sqy = $unsigned(64'(r_dy) * 64'(r_dy));

        // Stage 2: squared distance.
        n_sq_q[0]    = r_sqx + r_sqy;
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;

        // Square root, one result bit per stage.
        for (int j = 1; j <= SQN; j++) begin
            b = SQN - j;
            rem_sh = {r_sq_rem[j-1][pges_pkg::REM_W-3:0], r_sq_q[j-1][2*b +: 2]};
            trial  = pges_pkg::REM_W'({r_sq_root[j-1], 2'b01});
            n_sq_q[j] = r_sq_q[j-1];
            if (rem_sh >= trial) begin
                n_sq_rem[j]  = rem_sh - trial;
                n_sq_root[j] = {r_sq_root[j-1][pges_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_sq_rem[j]  = rem_sh;
                n_sq_root[j] = {r_sq_root[j-1][pges_pkg::ROOT_W-2:0], 1'b0};
            end
        end

        // Partial products of Q times R.
        n_pp_lo = pges_pkg::SQ_W'(r_sq_q[SQN][31:0]) * pges_pkg::SQ_W'(r_sq_root[SQN]);
        n_pp_hi = pges_pkg::SQ_W'(r_sq_q[SQN][63:32]) * pges_pkg::SQ_W'(r_sq_root[SQN]);

        // Divisor r^3 = Q * R.
        n_den = pges_pkg::DEN_W'(r_pp_lo) + (pges_pkg::DEN_W'(r_pp_hi) << 32);

        // Divider entry: scaled numerators and quotient overflow check.
        numx = NW'(r_pay[ST_DN].prx) << (2 * FRAC_BITS);
        numy = NW'(r_pay[ST_DN].pry) << (2 * FRAC_BITS);
        den_w = CW'(r_den);
        n_dv_den[0] = r_den;
        n_dv_px[0]  = numx;
        n_dv_py[0]  = numy;
        n_dv_qx[0]  = '0;
        n_dv_qy[0]  = '0;
        n_dv_ovx[0] = !r_pay[ST_DN].zero && ((CW'(numx) >> pges_pkg::QUO_W) >= den_w);
        n_dv_ovy[0] = !r_pay[ST_DN].zero && ((CW'(numy) >> pges_pkg::QUO_W) >= den_w);

        // Restoring division, one quotient bit per stage for both axes.
        for (int j = 1; j <= DVN; j++) begin
            k = DVN - j;
            den_w = CW'(r_dv_den[j-1]);
            sub   = den_w << k;
            topx  = CW'(r_dv_px[j-1]) >> k;
            topy  = CW'(r_dv_py[j-1]) >> k;
            gex   = topx >= den_w;
            gey   = topy >= den_w;
            n_dv_den[j] = r_dv_den[j-1];
            n_dv_ovx[j] = r_dv_ovx[j-1];
            n_dv_ovy[j] = r_dv_ovy[j-1];
            n_dv_px[j]  = gex ? (r_dv_px[j-1] - sub[NW-1:0]) : r_dv_px[j-1];
            n_dv_py[j]  = gey ? (r_dv_py[j-1] - sub[NW-1:0]) : r_dv_py[j-1];
            n_dv_qx[j]  = {r_dv_qx[j-1][pges_pkg::QUO_W-2:0], gex};
            n_dv_qy[j]  = {r_dv_qy[j-1][pges_pkg::QUO_W-2:0], gey};
        end

        // Acceleration and new velocity.
        ax  = pges_pkg::accel_of(r_dv_qx[DVN], r_dv_ovx[DVN],
                                 r_pay[ST_FA-1].negx, r_pay[ST_FA-1].zero);
        ay  = pges_pkg::accel_of(r_dv_qy[DVN], r_dv_ovy[DVN],
                                 r_pay[ST_FA-1].negy, r_pay[ST_FA-1].zero);
        nvx = pges_pkg::clamp_fix(34'(r_pay[ST_FA-1].vx) + 34'(ax.val));
        nvy = pges_pkg::clamp_fix(34'(r_pay[ST_FA-1].vy) + 34'(ay.val));
        n_pay[ST_FA].vx  = nvx.val;
        n_pay[ST_FA].vy  = nvy.val;
        n_pay[ST_FA].sat = r_pay[ST_FA-1].sat | ax.ovf | ay.ovf | nvx.ovf | nvy.ovf;

        // New position into the output register.
        npx = pges_pkg::clamp_fix(34'(r_pay[ST_FA].px) + 34'(r_pay[ST_FA].vx));
        npy = pges_pkg::clamp_fix(34'(r_pay[ST_FA].py) + 34'(r_pay[ST_FA].vy));
        n_pay[ST_OUT].px  = npx.val;
        n_pay[ST_OUT].py  = npy.val;
        n_pay[ST_OUT].sat = r_pay[ST_FA].sat | npx.ovf | npy.ovf;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= n_vld;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pay   <= n_pay;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_str   <= n_str;
            r_sqx   <= n_sqx;
            r_sqy   <= n_sqy;
            r_sq_q    <= n_sq_q;
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
            r_den   <= n_den;
            r_dv_den <= n_dv_den;
            r_dv_px  <= n_dv_px;
            r_dv_py  <= n_dv_py;
            r_dv_qx  <= n_dv_qx;
            r_dv_qy  <= n_dv_qy;
            r_dv_ovx <= n_dv_ovx;
            r_dv_ovy <= n_dv_ovy;
        end
    end

`ifndef SYNTHESIS
    // The root leaving the square-root pipe is the floor of the square root.
    a_sqrt_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_MP-1] |->
            (66'(r_sq_root[SQN]) * 66'(r_sq_root[SQN]) <= 66'(r_sq_q[SQN])) &&
            ((66'(r_sq_root[SQN]) + 66'd1) * (66'(r_sq_root[SQN]) + 66'd1)
                > 66'(r_sq_q[SQN])))
        else $error("square root stage result out of bounds");

    // Without x quotient overflow and at nonzero distance, the final x remainder is below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ST_FA-1] && !r_pay[ST_FA-1].zero && !r_dv_ovx[DVN]) |->
            (CW'(r_dv_px[DVN]) < CW'(r_dv_den[DVN])))
        else $error("divider remainder not below divisor");

    // The coincidence flag agrees with a zero squared distance.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_SQ0] |-> ((r_sq_q[0] == '0) == r_pay[ST_SQ0].zero))
        else $error("zero-distance flag disagrees with squared distance");

    // A stalled pipe keeps every valid bit in place.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld))
        else $error("pipeline moved while stalled");
`endif

endmodule

[bench/tb_point_gravity_euler_step_core.sv]
`timescale 1ns / 100ps

module tb_point_gravity_euler_step_core;

    localparam int      FRAC       = 16;
    localparam int      N_RANDOM   = 930;
    localparam int      N_CALM     = 100;
    localparam int      IDLE_LIMIT = 5000;
    localparam int      HOLD_START = 400;
    localparam int      HOLD_LEN   = 300;
    localparam longint  W_MAX      = 64'sd2147483647;
    localparam longint  W_MIN      = -64'sd2147483648;

    // One body and source pair as it enters the block.
    typedef struct {
        pges_pkg::t_fix                  px;
        pges_pkg::t_fix                  py;
        pges_pkg::t_fix                  vx;
        pges_pkg::t_fix                  vy;
        pges_pkg::t_fix                  sx;
        pges_pkg::t_fix                  sy;
        logic [pges_pkg::STR_W-1:0]      str;
    } t_body_item;

    // One updated body as it leaves the block.
    typedef struct {
        pges_pkg::t_fix pos_x;
        pges_pkg::t_fix pos_y;
        pges_pkg::t_fix vel_x;
        pges_pkg::t_fix vel_y;
        bit             zero_dist;
        bit             sat;
    } t_body_state;

    // Predicts each Euler step and compares the block's results in order.
    class gravity_scoreboard;
        t_body_state pending_steps[$];
        int          mismatches;

        function new();
            mismatches = 0;
        endfunction

        function automatic longint clamp_w(longint v, inout bit sat);
            if (v > W_MAX) begin
                sat = 1'b1;
                return W_MAX;
            end
            if (v < W_MIN) begin
                sat = 1'b1;
                return W_MIN;
            end
            return v;
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned x);
            longint unsigned root;
            longint unsigned bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > x) bitv >>= 2;
            while (bitv != 0) begin
                if (x >= root + bitv) begin
                    x    = x - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv >>= 2;
            end
            return root;
        endfunction

        // Acceleration along one axis: strength * d * 2^(2*FRAC) / (Q * R), truncated and clamped.
        function automatic longint accel_axis(longint d, longint unsigned str,
                                              longint unsigned qd, longint unsigned rt,
                                              inout bit sat);
            logic [127:0] num;
            logic [127:0] den;
            logic [127:0] mag;
            logic [127:0] lim;
            longint unsigned dmag;
            dmag = (d < 0) ? longint'(-d) : longint'(d);
            num  = (128'(str) * 128'(dmag)) << (2 * FRAC);
            den  = 128'(qd) * 128'(rt);
            mag  = num / den;
            lim  = (d < 0) ? 128'd2147483648 : 128'd2147483647;
            if (mag > lim) begin
                sat = 1'b1;
                mag = lim;
            end
            return (d < 0) ? -longint'(mag[63:0]) : longint'(mag[63:0]);
        endfunction

        function void note_input(t_body_item it);
            t_body_state     res;
            bit              sat;
            longint          dx, dy, ax, ay, nvx, nvy;
            longint unsigned qd, rt;
            sat = 1'b0;
            ax  = 0;
            ay  = 0;
            dx  = clamp_w(longint'(it.sx) - longint'(it.px), sat);
            dy  = clamp_w(longint'(it.sy) - longint'(it.py), sat);
            res.zero_dist = (dx == 0) && (dy == 0);
            if (!res.zero_dist) begin
                qd = longint'(dx * dx) + longint'(dy * dy);
                rt = int_sqrt(qd);
                ax = accel_axis(dx, it.str, qd, rt, sat);
                ay = accel_axis(dy, it.str, qd, rt, sat);
            end
            // Semi-implicit: the position moves by the already updated velocity.
            nvx = clamp_w(longint'(it.vx) + ax, sat);
            nvy = clamp_w(longint'(it.vy) + ay, sat);
            res.vel_x = pges_pkg::t_fix'(nvx);
            res.vel_y = pges_pkg::t_fix'(nvy);
            res.pos_x = pges_pkg::t_fix'(clamp_w(longint'(it.px) + nvx, sat));
            res.pos_y = pges_pkg::t_fix'(clamp_w(longint'(it.py) + nvy, sat));
            res.sat   = sat;
            pending_steps.insert(pending_steps.size(), res);
        endfunction

        function void check_result(logic [pges_pkg::OUT_W-1:0] data, logic [1:0] user);
            t_body_state exp_st;
            longint      exp_f[6];
            longint      act_f[6];
            string       names[6];
            bit          bad;
            if (pending_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with nothing expected: %h", data);
                return;
            end
            exp_st = pending_steps.pop_front();
            names = '{"new_pos_x", "new_pos_y", "new_vel_x", "new_vel_y",
                      "zero_distance", "saturated"};
            exp_f = '{exp_st.pos_x, exp_st.pos_y, exp_st.vel_x, exp_st.vel_y,
                      exp_st.zero_dist, exp_st.sat};
            act_f = '{pges_pkg::t_fix'(data[31:0]), pges_pkg::t_fix'(data[63:32]),
                      pges_pkg::t_fix'(data[95:64]), pges_pkg::t_fix'(data[127:96]),
                      user[0], user[1]};
            bad = 1'b0;
            foreach (names[i]) begin
                if (exp_f[i] != act_f[i]) begin
                    if (!bad) mismatches++;
                    bad = 1'b1;
                    if (mismatches <= 10)
                        $display("ERROR: %s expected %0d got %0d", names[i], exp_f[i],
                                 act_f[i]);
                end
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pges_pkg::IN_W-1:0]      s_axis_tdata = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pges_pkg::OUT_W-1:0]     m_axis_tdata;
    logic [1:0]                     m_axis_tuser;

    gravity_scoreboard    sb = new();
    bit                   calm_phase = 1'b0;
    int                   cycle_count = 0;
    int                   idle_cycles = 0;

    point_gravity_euler_step_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one pair, with an optional gap first, and waits for the transaction.
    task automatic send_pair(t_body_item it, bit allow_gap);
        if (allow_gap && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.str, it.sy, it.sx, it.vy, it.vx, it.py, it.px};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(it);
    endtask

    function automatic t_body_item make_pair(pges_pkg::t_fix px, pges_pkg::t_fix py,
                                             pges_pkg::t_fix vx, pges_pkg::t_fix vy,
                                             pges_pkg::t_fix sx, pges_pkg::t_fix sy,
                                             logic [pges_pkg::STR_W-1:0] str);
        t_body_item it;
        it = '{px, py, vx, vy, sx, sy, str};
        return it;
    endfunction

    // Random pair: mostly a source near the body so the pull is meaningful.
    function automatic t_body_item random_pair();
        t_body_item it;
        int         mode;
        mode   = $urandom_range(0, 9);
        it.px  = $urandom;
        it.py  = $urandom;
        it.vx  = $signed($urandom) >>> $urandom_range(0, 31);
        it.vy  = $signed($urandom) >>> $urandom_range(0, 31);
        it.str = 24'($urandom);
        it.sx  = it.px + ($signed($urandom) >>> $urandom_range(0, 31));
        it.sy  = it.py + ($signed($urandom) >>> $urandom_range(0, 31));
        if (mode == 0) begin
            it.sx = $urandom;
            it.sy = $urandom;
            it.vx = $urandom;
            it.vy = $urandom;
        end else if (mode == 1) begin
            it.sx = it.px;
            it.sy = it.py;
        end else if (mode == 2) begin
            it.sx = it.px + $signed($urandom_range(0, 6)) - 3;
            it.sy = it.py + $signed($urandom_range(0, 6)) - 3;
        end
        return it;
    endfunction

    // Reset, then a directed set of corners, then random pairs.
    initial begin
        t_body_item     directed[$];
        pges_pkg::t_fix mx;
        pges_pkg::t_fix mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Coincident points, with and without motion.
        directed = {directed, make_pair(0, 0, 0, 0, 0, 0, 24'hFFFFFF)};
        directed = {directed, make_pair(mx, mn, mx, mn, mx, mn, 24'h010000)};
        // Offsets that clamp in both directions.
        directed = {directed, make_pair(mn, mx, 0, 0, mx, mn, 24'hFFFFFF)};
        directed = {directed, make_pair(mx, mn, 0, 0, mn, mx, 24'h000001)};
        // Tiny distances, most with full strength, give a clamped pull.
        directed = {directed, make_pair(0, 0, 0, 0, 1, 0, 24'hFFFFFF)};
        directed = {directed, make_pair(0, 0, 0, 0, -1, 0, 24'hFFFFFF)};
        directed = {directed, make_pair(0, 0, 0, 0, 0, -1, 24'hFFFFFF)};
        directed = {directed, make_pair(5, 7, 0, 0, 6, 6, 24'h000001)};
        // Zero strength at unit distance, then unit strength at a diagonal offset.
        directed = {directed, make_pair(0, 0, 100, -100, 32'sh10000, 0, 24'h000000)};
        directed = {directed, make_pair(0, 0, 0, 0, 32'sh10000, 32'sh10000, 24'h010000)};
        // Velocity and position sums that clamp.
        directed = {directed, make_pair(mx, mx, mx, mx, mx, mx, 24'h000000)};
        directed = {directed, make_pair(mn, mn, mn, mn, mn, mn, 24'h000000)};
        directed = {directed, make_pair(mx, 0, mx, 0, 0, 0, 24'hFFFFFF)};
        directed = {directed, make_pair(mn, 0, mn, 0, 0, 0, 24'hFFFFFF)};
        directed = {directed, make_pair(0, 0, mx, mn, 32'sh20000, -32'sh20000,
                                        24'hFFFFFF)};
        directed = {directed, make_pair(-1, -1, -1, -1, 0, 0, 24'h800000)};
        directed = {directed, make_pair(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555,
                                        32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555,
                                        24'h555555)};
        foreach (directed[i]) send_pair(directed[i], 1'b0);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - N_CALM) calm_phase = 1'b1;
            send_pair(random_pair(), !calm_phase);
        end
        s_axis_tvalid <= 1'b0;
        while (sb.pending_steps.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("PASS point_gravity_euler_step_core");
        end else begin
            $display("FAIL point_gravity_euler_step_core");
        end
        $finish;
    end

    // Result side: check each transaction, then pick the next ready value.
    always @(posedge i_clk) begin
        automatic logic nxt_ready;
        static int      hold_left = 0;
        static int      stall_left = 0;
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
        cycle_count++;
        if (cycle_count == HOLD_START) hold_left = HOLD_LEN;
        if (!i_rst_n) begin
            nxt_ready = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            nxt_ready = 1'b0;
        end else if (calm_phase) begin
            nxt_ready = 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            nxt_ready = 1'b0;
        end else if ($urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            nxt_ready = 1'b0;
        end else begin
            nxt_ready = 1'b1;
        end
        m_axis_tready <= nxt_ready;
    end

    // Watchdog: too long without any transaction on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("FAIL point_gravity_euler_step_core");
            $finish;
        end
    end

endmodule
